FILE: rtl/afmd_pkg.sv
// Shared types and constants for the accelerometer frame magnitude decimator.
`default_nettype none

package afmd_pkg;

    localparam int FRAME_BYTES = 6;
    localparam int HELD_BYTES  = FRAME_BYTES - 1;
    localparam int AXIS_W      = 16;
    localparam int SUM_W       = 32;
    localparam int RATIO_W     = 16;

    localparam logic [2:0]         LAST_POS    = 3'(FRAME_BYTES - 1);
    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd200;

    // Register index carried in paddr[2].
    localparam logic REG_RATIO = 1'b0;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_ROOT   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/accel_frame_magnitude_decimator.sv
// The sixth byte of a frame starts the computation of its result word.
// Squares are formed two multiplier bits per cycle, one axis after another (X, Y, Z),
// and the root one result bit per cycle; these serial units set the rate.
// The next frame's first five bytes load meanwhile; its sixth byte waits for idle.
// Reset (rst_n, asynchronous, active low): byte position and frame count to zero,
// decimation ratio to 200, no result pending.
`default_nettype none

module accel_frame_magnitude_decimator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire logic [7:0]         fifo_byte,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic signed [15:0]      accel_x,
    output logic signed [15:0]      accel_y,
    output logic signed [15:0]      accel_z,
    output logic      [15:0]        magnitude,
    output logic                    stream_select
);

    function automatic logic [15:0] abs16(input logic [15:0] w);
        abs16 = w[15] ? (~w + 16'd1) : w;
    endfunction

    afmd_pkg::state_t state_reg, state_next;

    logic [15:0] ratio_reg, ratio_next;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  held_reg [afmd_pkg::HELD_BYTES];
    logic [15:0] frame_count_reg, frame_count_next;

    logic [15:0] wx_reg, wx_next;
    logic [15:0] wy_reg, wy_next;
    logic [15:0] wz_reg, wz_next;
    logic [31:0] sum_reg, sum_next;
    logic [15:0] acand_reg, acand_next;
    logic [15:0] mpy_reg, mpy_next;
    logic [2:0]  dig_reg, dig_next;
    logic [1:0]  axis_reg, axis_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] root_reg, root_next;
    logic [3:0]  rcnt_reg, rcnt_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_x_reg, out_x_next;
    logic [15:0] out_y_reg, out_y_next;
    logic [15:0] out_z_reg, out_z_next;
    logic [15:0] out_mag_reg, out_mag_next;
    logic        out_flag_reg, out_flag_next;

    logic        byte_take;
    logic        cfg_write;
    logic [17:0] pp;
    logic [31:0] pp_shifted;
    logic [18:0] rem_sh;
    logic [18:0] trial;
    logic        trial_ge;
    logic [16:0] cnt_inc;
    logic        flag;
    logic        out_free;
    logic [15:0] next_axis_word;

    // The last byte of a frame may only enter when the arithmetic unit is free.
    assign byte_ready = (pos_reg != afmd_pkg::LAST_POS) || (state_reg == afmd_pkg::ST_IDLE);
    assign byte_take  = byte_valid && byte_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == afmd_pkg::REG_RATIO);
    assign prdata    = (paddr[2] == afmd_pkg::REG_RATIO) ? {16'd0, ratio_reg} : 32'd0;

    // One radix-4 digit of the multiplier times the magnitude of the axis.
    assign pp = ({18{mpy_reg[0]}} & {2'b00, acand_reg})
              + ({18{mpy_reg[1]}} & {1'b0, acand_reg, 1'b0});
    assign pp_shifted = {14'd0, pp} << {dig_reg, 1'b0};

    // Bit-serial restoring square root, two radicand bits per step.
    assign rem_sh   = {rem_reg, sum_reg[31:30]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign trial_ge = rem_sh >= trial;

    assign cnt_inc  = {1'b0, frame_count_reg} + 17'd1;
    assign flag     = cnt_inc >= {1'b0, ratio_reg};
    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        unique case (axis_reg)
            afmd_pkg::AXIS_X: next_axis_word = wy_reg;
            afmd_pkg::AXIS_Y: next_axis_word = wz_reg;
            default:          next_axis_word = wx_reg;
        endcase
    end

    always_comb
    begin
        ratio_next       = cfg_write ? pwdata[15:0] : ratio_reg;
        pos_next         = pos_reg;
        frame_count_next = frame_count_reg;
        state_next       = state_reg;
        wx_next          = wx_reg;
        wy_next          = wy_reg;
        wz_next          = wz_reg;
        sum_next         = sum_reg;
        acand_next       = acand_reg;
        mpy_next         = mpy_reg;
        dig_next         = dig_reg;
        axis_next        = axis_reg;
        rem_next         = rem_reg;
        root_next        = root_reg;
        rcnt_next        = rcnt_reg;
        out_valid_next   = out_valid_reg && !result_ready;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_z_next       = out_z_reg;
        out_mag_next     = out_mag_reg;
        out_flag_next    = out_flag_reg;

        if (byte_take)
        begin
            pos_next = (pos_reg == afmd_pkg::LAST_POS) ? 3'd0 : pos_reg + 3'd1;
        end

        unique case (state_reg)
            afmd_pkg::ST_IDLE:
            begin
                if (byte_take && (pos_reg == afmd_pkg::LAST_POS))
                begin
                    wx_next    = {held_reg[0], held_reg[1]};
                    wy_next    = {held_reg[2], held_reg[3]};
                    wz_next    = {held_reg[4], fifo_byte};
                    acand_next = abs16({held_reg[0], held_reg[1]});
                    mpy_next   = abs16({held_reg[0], held_reg[1]});
                    sum_next   = 32'd0;
                    dig_next   = 3'd0;
                    axis_next  = afmd_pkg::AXIS_X;
                    state_next = afmd_pkg::ST_SQUARE;
                end
            end
            afmd_pkg::ST_SQUARE:
            begin
                sum_next = sum_reg + pp_shifted;
                mpy_next = {2'b00, mpy_reg[15:2]};
                dig_next = dig_reg + 3'd1;
                if (dig_reg == 3'd7)
                begin
                    if (axis_reg == afmd_pkg::AXIS_Z)
                    begin
                        rem_next   = 17'd0;
                        root_next  = 16'd0;
                        rcnt_next  = 4'd0;
                        state_next = afmd_pkg::ST_ROOT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        acand_next = abs16(next_axis_word);
                        mpy_next   = abs16(next_axis_word);
                    end
                end
            end
            afmd_pkg::ST_ROOT:
            begin
                sum_next  = {sum_reg[29:0], 2'b00};
                rem_next  = trial_ge ? 17'(rem_sh - trial) : rem_sh[16:0];
                root_next = {root_reg[14:0], trial_ge};
                rcnt_next = rcnt_reg + 4'd1;
                if (rcnt_reg == 4'd15)
                begin
                    state_next = afmd_pkg::ST_DONE;
                end
            end
            afmd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_x_next       = wx_reg;
                    out_y_next       = wy_reg;
                    out_z_next       = wz_reg;
                    out_mag_next     = root_reg;
                    out_flag_next    = flag;
                    frame_count_next = flag ? 16'd0 : cnt_inc[15:0];
                    state_next       = afmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = afmd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= afmd_pkg::ST_IDLE;
            ratio_reg       <= afmd_pkg::RATIO_RESET;
            pos_reg         <= 3'd0;
            frame_count_reg <= 16'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ratio_reg       <= ratio_next;
            pos_reg         <= pos_next;
            frame_count_reg <= frame_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take && (pos_reg != afmd_pkg::LAST_POS))
        begin
            held_reg[pos_reg] <= fifo_byte;
        end
        wx_reg       <= wx_next;
        wy_reg       <= wy_next;
        wz_reg       <= wz_next;
        sum_reg      <= sum_next;
        acand_reg    <= acand_next;
        mpy_reg      <= mpy_next;
        dig_reg      <= dig_next;
        axis_reg     <= axis_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        rcnt_reg     <= rcnt_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_z_reg    <= out_z_next;
        out_mag_reg  <= out_mag_next;
        out_flag_reg <= out_flag_next;
    end

    assign result_valid  = out_valid_reg;
    assign accel_x       = out_x_reg;
    assign accel_y       = out_y_reg;
    assign accel_z       = out_z_reg;
    assign magnitude     = out_mag_reg;
    assign stream_select = out_flag_reg;

endmodule

`default_nettype wire
